// File: hdl/alert_cooldown_fsm_top_assert.svh
// ----------------------------------------------------------------------------
// alert_cooldown_fsm_top_assert
// assertion macros shared by the alert cooldown rtl
// ----------------------------------------------------------------------------
// all checks are clocked on clk and disabled while rst_n is low
`ifndef ALERT_COOLDOWN_FSM_TOP_ASSERT_SVH
`define ALERT_COOLDOWN_FSM_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define ACF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alert cooldown check failed");

// consequent in the cycle after the antecedent
`define ACF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alert cooldown check failed");

`endif

// File: hdl/acf_pkg.sv
// ----------------------------------------------------------------------------
// acf_pkg
// codes, widths and register reset values of the alert cooldown block
// ----------------------------------------------------------------------------
package acf_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    // padded beat widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 72;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_TRIGGER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MUTE    = 2'd2;

    // requested alert kinds
    localparam logic [KIND_W-1:0] KIND_SMOKE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOOR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOKE_DUR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_DUR   = 2'd2;

    localparam logic [TIME_W-1:0] COOLDOWN_RST  = 32'd5000;
    localparam logic [TIME_W-1:0] SMOKE_DUR_RST = 32'd2000;
    localparam logic [TIME_W-1:0] DOOR_DUR_RST  = 32'd1200;

endpackage

// File: hdl/alert_cooldown_fsm_top.sv
// ----------------------------------------------------------------------------
// alert_cooldown_fsm_top
// none / smoke / doorbell alert machine with per-kind trigger cooldown
// ----------------------------------------------------------------------------
// an input beat passes the input register, then the result register, as a result beat
// throughput: one beat per cycle unless the result stream stalls; the state update
// is a single pass of 32-bit subtract and compare between the input and result registers
// reset: rst_n clears the alert state, start and last-trigger times, mute flag
// and loads the registers with cooldown 5000, smoke 2000, doorbell 1200
`include "alert_cooldown_fsm_top_assert.svh"

module alert_cooldown_fsm_top
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // alert_type[1:0], now_ms[33:2], mute_value[34], zero pad [39:35]
    input  logic [acf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // action[1:0]
    input  logic [acf_pkg::ACTION_W-1:0]       s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // alert_state[1:0], elapsed_ms[33:2], alert_start_ms[65:34],
    // muted_flag[66], zero pad [71:67]
    output logic [acf_pkg::M_TDATA_W-1:0]      m_axis_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acf_pkg::TIME_W-1:0]         cfg_data
);

    typedef enum logic [1:0]
    {
        ST_NONE  = 2'd0,
        ST_SMOKE = 2'd1,
        ST_DOOR  = 2'd2
    } alert_t;

    // configuration
    logic [acf_pkg::TIME_W-1:0] cooldown_reg;
    logic [acf_pkg::TIME_W-1:0] smoke_dur_reg;
    logic [acf_pkg::TIME_W-1:0] door_dur_reg;

    // input stage
    logic                         in_valid_reg;
    logic [acf_pkg::ACTION_W-1:0] in_action_reg;
    logic [acf_pkg::KIND_W-1:0]   in_kind_reg;
    logic [acf_pkg::TIME_W-1:0]   in_now_reg;
    logic                         in_mute_reg;

    // machine state
    alert_t                     alert_reg;
    alert_t                     alert_next;
    logic [acf_pkg::TIME_W-1:0] start_reg;
    logic [acf_pkg::TIME_W-1:0] start_next;
    logic [acf_pkg::TIME_W-1:0] last_smoke_reg;
    logic [acf_pkg::TIME_W-1:0] last_smoke_next;
    logic [acf_pkg::TIME_W-1:0] last_door_reg;
    logic [acf_pkg::TIME_W-1:0] last_door_next;
    logic                       mute_reg;
    logic                       mute_next;

    // result stage
    logic                         out_valid_reg;
    logic [acf_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [acf_pkg::M_TDATA_W-1:0] out_data_next;

    logic                       advance;
    logic [acf_pkg::TIME_W-1:0] since_last;
    logic [acf_pkg::TIME_W-1:0] since_start;
    logic [acf_pkg::TIME_W-1:0] elapsed;
    logic                       cooled;
    logic                       trig_ok;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooldown_reg  <= acf_pkg::COOLDOWN_RST;
            smoke_dur_reg <= acf_pkg::SMOKE_DUR_RST;
            door_dur_reg  <= acf_pkg::DOOR_DUR_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                acf_pkg::REG_COOLDOWN:  cooldown_reg  <= cfg_data;
                acf_pkg::REG_SMOKE_DUR: smoke_dur_reg <= cfg_data;
                acf_pkg::REG_DOOR_DUR:  door_dur_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_kind_reg   <= s_axis_tdata[1:0];
            in_now_reg    <= s_axis_tdata[33:2];
            in_mute_reg   <= s_axis_tdata[34];
        end
    end

    // trigger cooldown and update timeout checks, mute update and result beat packing
    always_comb
    begin
        since_last  = in_now_reg - ((in_kind_reg == acf_pkg::KIND_SMOKE) ?
                                    last_smoke_reg : last_door_reg);
        since_start = in_now_reg - start_reg;
        cooled      = (since_last >= cooldown_reg);
        trig_ok     = !mute_reg && (alert_reg == ST_NONE) && cooled &&
                      ((in_kind_reg == acf_pkg::KIND_SMOKE) ||
                       (in_kind_reg == acf_pkg::KIND_DOOR));

        alert_next      = alert_reg;
        start_next      = start_reg;
        last_smoke_next = last_smoke_reg;
        last_door_next  = last_door_reg;
        mute_next       = mute_reg;

        unique case (in_action_reg)
            acf_pkg::ACT_TRIGGER:
            begin
                if (trig_ok)
                begin
                    start_next = in_now_reg;
                    if (in_kind_reg == acf_pkg::KIND_SMOKE)
                    begin
                        alert_next      = ST_SMOKE;
                        last_smoke_next = in_now_reg;
                    end
                    else
                    begin
                        alert_next     = ST_DOOR;
                        last_door_next = in_now_reg;
                    end
                end
            end
            acf_pkg::ACT_UPDATE:
            begin
                if ((alert_reg == ST_SMOKE && since_start >= smoke_dur_reg) ||
                    (alert_reg == ST_DOOR && since_start >= door_dur_reg))
                    alert_next = ST_NONE;
            end
            acf_pkg::ACT_MUTE:
                mute_next = in_mute_reg;
            default: ;
        endcase

        elapsed       = in_now_reg - start_next;
        out_data_next = {5'd0, mute_next, start_next, elapsed, alert_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alert_reg      <= ST_NONE;
            start_reg      <= '0;
            last_smoke_reg <= '0;
            last_door_reg  <= '0;
            mute_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                alert_reg      <= alert_next;
                start_reg      <= start_next;
                last_smoke_reg <= last_smoke_next;
                last_door_reg  <= last_door_next;
                mute_reg       <= mute_next;
                out_valid_reg  <= 1'b1;
                out_data_reg   <= out_data_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // a muted trigger never changes the alert
    `ACF_ASSERT_NEXT(a_mute_blocks,
        advance && in_action_reg == acf_pkg::ACT_TRIGGER && mute_reg,
        alert_reg == $past(alert_reg))
    // a new alert records the trigger time as its start
    `ACF_ASSERT_NEXT(a_start_on_trigger,
        advance && alert_reg == ST_NONE && alert_next != ST_NONE,
        start_reg == $past(in_now_reg))
    // an active alert leaves only through an update
    `ACF_ASSERT_SAME(a_clear_by_update,
        alert_reg != ST_NONE && alert_next != alert_reg,
        in_action_reg == acf_pkg::ACT_UPDATE)

endmodule

// File: test/alert_cooldown_fsm_top_test.sv
// ----------------------------------------------------------------------------
// alert_cooldown_fsm_top_test
// self-checking bench for the alert cooldown state machine: directed beats for
// the cooldown, mute, wrap and ignore cases, then random event streams with
// time advancing in steps, under several register settings, with random
// stalls on both streams and every result checked against a local model
// ----------------------------------------------------------------------------
module alert_cooldown_fsm_top_test;

    typedef enum logic [1:0]
    {
        EXP_IDLE  = 2'd0,
        EXP_SMOKE = 2'd1,
        EXP_DOOR  = 2'd2
    } exp_alert_t;

    typedef struct
    {
        exp_alert_t state;
        logic [acf_pkg::TIME_W-1:0] elapsed;
        logic [acf_pkg::TIME_W-1:0] start;
        logic muted;
    } alert_result_t;

    // codes with no meaning to the block
    localparam logic [acf_pkg::ACTION_W-1:0] ACT_SPARE  = 2'd3;
    localparam logic [acf_pkg::KIND_W-1:0]   KIND_NONE  = 2'd0;
    localparam logic [acf_pkg::KIND_W-1:0]   KIND_SPARE = 2'd3;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    class alert_scoreboard;
        logic [acf_pkg::TIME_W-1:0] cooldown_ms;
        logic [acf_pkg::TIME_W-1:0] smoke_dur_ms;
        logic [acf_pkg::TIME_W-1:0] door_dur_ms;
        exp_alert_t                 active;
        logic [acf_pkg::TIME_W-1:0] start_ms;
        logic [acf_pkg::TIME_W-1:0] last_smoke_ms;
        logic [acf_pkg::TIME_W-1:0] last_door_ms;
        logic                       muted;
        alert_result_t              expected_q[$];
        int unsigned                errors;
        int unsigned                items_seen;
        int unsigned                results_seen;
        int unsigned                alerts_raised;
        int unsigned                alerts_cleared;
        int unsigned                reg_writes;

        function new();
            cooldown_ms   = acf_pkg::COOLDOWN_RST;
            smoke_dur_ms  = acf_pkg::SMOKE_DUR_RST;
            door_dur_ms   = acf_pkg::DOOR_DUR_RST;
            active        = EXP_IDLE;
            start_ms      = '0;
            last_smoke_ms = '0;
            last_door_ms  = '0;
            muted         = 1'b0;
        endfunction

        function void write_reg(logic [acf_pkg::CFG_IDX_W-1:0] index,
                                logic [acf_pkg::TIME_W-1:0] value);
            reg_writes++;
            case (index)
                acf_pkg::REG_COOLDOWN:  cooldown_ms  = value;
                acf_pkg::REG_SMOKE_DUR: smoke_dur_ms = value;
                acf_pkg::REG_DOOR_DUR:  door_dur_ms  = value;
                default: ;
            endcase
        endfunction

        // advance the alert state by one event and queue the result it gives
        function void note_input(logic [acf_pkg::ACTION_W-1:0] action,
                                 logic [acf_pkg::KIND_W-1:0] kind,
                                 logic [acf_pkg::TIME_W-1:0] now, logic mute_v);
            logic [acf_pkg::TIME_W-1:0] since;
            alert_result_t              res;
            items_seen++;
            case (action)
                acf_pkg::ACT_TRIGGER:
                begin
                    if (!muted && active == EXP_IDLE)
                    begin
                        if (kind == acf_pkg::KIND_SMOKE)
                        begin
                            since = now - last_smoke_ms;
                            if (since >= cooldown_ms)
                            begin
                                last_smoke_ms = now;
                                active        = EXP_SMOKE;
                                start_ms      = now;
                                alerts_raised++;
                            end
                        end
                        else if (kind == acf_pkg::KIND_DOOR)
                        begin
                            since = now - last_door_ms;
                            if (since >= cooldown_ms)
                            begin
                                last_door_ms = now;
                                active       = EXP_DOOR;
                                start_ms     = now;
                                alerts_raised++;
                            end
                        end
                    end
                end
                acf_pkg::ACT_UPDATE:
                begin
                    since = now - start_ms;
                    if ((active == EXP_SMOKE && since >= smoke_dur_ms) ||
                        (active == EXP_DOOR && since >= door_dur_ms))
                    begin
                        active = EXP_IDLE;
                        alerts_cleared++;
                    end
                end
                acf_pkg::ACT_MUTE: muted = mute_v;
                default: ;
            endcase
            res.state   = active;
            res.elapsed = now - start_ms;
            res.start   = start_ms;
            res.muted   = muted;
            expected_q.push_back(res);
        endfunction

        function void report(string field, logic [acf_pkg::TIME_W-1:0] want,
                             logic [acf_pkg::TIME_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        endfunction

        function void check_result(logic [acf_pkg::M_TDATA_W-1:0] beat);
            alert_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat 0x%0h with nothing expected", $time, beat);
                return;
            end
            want = expected_q.pop_front();
            if (beat[1:0] !== want.state)
                report("alert_state", acf_pkg::TIME_W'(want.state),
                       acf_pkg::TIME_W'(beat[1:0]));
            if (beat[33:2] !== want.elapsed)
                report("elapsed_ms", want.elapsed, beat[33:2]);
            if (beat[65:34] !== want.start)
                report("alert_start_ms", want.start, beat[65:34]);
            if (beat[66] !== want.muted)
                report("muted_flag", acf_pkg::TIME_W'(want.muted),
                       acf_pkg::TIME_W'(beat[66]));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [acf_pkg::S_TDATA_W-1:0]     s_axis_tdata = '0;
    logic [acf_pkg::ACTION_W-1:0]      s_axis_tuser = acf_pkg::ACT_UPDATE;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [acf_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [acf_pkg::CFG_IDX_W-1:0]     cfg_index = acf_pkg::REG_COOLDOWN;
    logic [acf_pkg::TIME_W-1:0]        cfg_data = '0;

    alert_scoreboard                   sb = new();
    logic                              calm = 1'b0;
    logic [acf_pkg::TIME_W-1:0]        clock_ms = '0;
    int unsigned                       quiet_cycles = 0;

    alert_cooldown_fsm_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 29);

    // result check before input note, so a stray beat never matches a fresh event
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[33:2],
                          s_axis_tdata[34]);
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, sb.pending());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_event(input logic [acf_pkg::ACTION_W-1:0] action,
                              input logic [acf_pkg::KIND_W-1:0] kind,
                              input logic [acf_pkg::TIME_W-1:0] now, input logic mute_v);
        while (!calm && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {5'd0, mute_v, now, kind};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // hold the input stream until every queued result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_registers(input logic [acf_pkg::TIME_W-1:0] cooldown,
                                 input logic [acf_pkg::TIME_W-1:0] smoke,
                                 input logic [acf_pkg::TIME_W-1:0] door);
        logic [acf_pkg::CFG_IDX_W-1:0] idx [3];
        logic [acf_pkg::TIME_W-1:0]    val [3];
        idx = '{acf_pkg::REG_COOLDOWN, acf_pkg::REG_SMOKE_DUR, acf_pkg::REG_DOOR_DUR};
        val = '{cooldown, smoke, door};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
            begin
                @(posedge clk);
            end
            while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(input int unsigned count, input int unsigned span);
        logic [acf_pkg::ACTION_W-1:0] action;
        logic [acf_pkg::KIND_W-1:0]   kind;
        logic [acf_pkg::TIME_W-1:0]   delta;
        logic                         mute_v;
        int unsigned                  pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                action = acf_pkg::ACT_TRIGGER;
            else if (pick < 85)
                action = acf_pkg::ACT_UPDATE;
            else if (pick < 96)
                action = acf_pkg::ACT_MUTE;
            else
                action = ACT_SPARE;
            if ($urandom_range(9) < 8)
                kind = $urandom_range(1) ? acf_pkg::KIND_SMOKE : acf_pkg::KIND_DOOR;
            else
                kind = $urandom_range(1) ? KIND_SPARE : KIND_NONE;
            // time mostly moves forward in steps near the register scale
            pick = $urandom_range(99);
            if (pick < 10)
                delta = '0;
            else if (pick < 15)
                delta = 32'd1;
            else if (pick < 20)
                delta = '1;
            else if (pick < 88)
                delta = $urandom_range(span);
            else
                delta = $urandom;
            clock_ms = clock_ms + delta;
            // unmute more often than mute so triggers keep getting through
            if (action == acf_pkg::ACT_MUTE)
                mute_v = ($urandom_range(9) < 3);
            else
                mute_v = 1'($urandom);
            send_event(action, kind, clock_ms, mute_v);
            if ($urandom_range(59) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: cooldown 5000, smoke 2000, doorbell 1200
        // blocked by cooldown from reset
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_SMOKE, 32'd100, 1'b0);
        // nothing active
        send_event(acf_pkg::ACT_UPDATE, KIND_NONE, 32'd200, 1'b0);
        // unknown kinds ignored
        send_event(acf_pkg::ACT_TRIGGER, KIND_NONE, 32'd6000, 1'b0);
        send_event(acf_pkg::ACT_TRIGGER, KIND_SPARE, 32'd6000, 1'b1);
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_SMOKE, 32'd6000, 1'b0);
        // already active
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_DOOR, 32'd6500, 1'b0);
        // one short of the duration
        send_event(acf_pkg::ACT_UPDATE, acf_pkg::KIND_SMOKE, 32'd7999, 1'b0);
        send_event(acf_pkg::ACT_UPDATE, acf_pkg::KIND_SMOKE, 32'd8000, 1'b0);
        // within smoke cooldown
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_SMOKE, 32'd9000, 1'b0);
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_DOOR, 32'd9000, 1'b0);
        wait_drained();
        // mute while doorbell active
        send_event(acf_pkg::ACT_MUTE, acf_pkg::KIND_DOOR, 32'd9100, 1'b1);
        // still clears while muted
        send_event(acf_pkg::ACT_UPDATE, KIND_NONE, 32'd10200, 1'b0);
        // muted
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_DOOR, 32'd20000, 1'b0);
        send_event(ACT_SPARE, KIND_SPARE, 32'hFFFF_FFFF, 1'b1);
        send_event(acf_pkg::ACT_MUTE, KIND_NONE, 32'd0, 1'b0);
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_SMOKE, 32'hFFFF_FFF0, 1'b0);
        // wraps past zero
        send_event(acf_pkg::ACT_UPDATE, acf_pkg::KIND_SMOKE, 32'h0000_07D0, 1'b0);
        send_event(acf_pkg::ACT_TRIGGER, acf_pkg::KIND_DOOR, 32'hFFFF_FFFF, 1'b0);
        send_event(acf_pkg::ACT_UPDATE, acf_pkg::KIND_DOOR, 32'h0000_04AE, 1'b1);
        send_event(acf_pkg::ACT_UPDATE, acf_pkg::KIND_DOOR, 32'h0000_04AF, 1'b0);
        clock_ms = 32'h0000_04AF;
        random_burst(100, 8000);

        wait_drained();
        set_registers('0, '0, '0);
        random_burst(100, 50);

        wait_drained();
        set_registers('1, '1, '1);
        random_burst(80, 16);

        // no stalls on either side for this stretch
        wait_drained();
        calm <= 1'b1;
        set_registers($urandom_range(300), $urandom_range(300), $urandom_range(300));
        random_burst(100, 400);
        wait_drained();
        calm <= 1'b0;

        set_registers($urandom, $urandom, $urandom);
        random_burst(60, $urandom_range(32'h00FF_FFFF));
        wait_drained();
        set_registers($urandom_range(20000), $urandom_range(20000), $urandom_range(20000));
        random_burst(60, 30000);

        wait_drained();
        set_registers(acf_pkg::COOLDOWN_RST, acf_pkg::SMOKE_DUR_RST, acf_pkg::DOOR_DUR_RST);
        random_burst(100, 8000);

        wait_drained();
        repeat (4) @(posedge clk);
        $display("covered %0d events and %0d results over %0d register writes",
                 sb.items_seen, sb.results_seen, sb.reg_writes);
        $display("alerts raised %0d, cleared by timeout %0d, mismatches %0d",
                 sb.alerts_raised, sb.alerts_cleared, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
